>>> rtl/core/dllc_pkg.sv
// Package for the doubly linked list with cursor: sizes, op codes, status codes, FSM states.
// No dependencies.
package dllc_pkg;
    localparam int PoolSize  = 64;
    localparam int IdxW      = $clog2(PoolSize);
    localparam int CntW      = IdxW + 1;
    localparam int DataWidth = 32;

    typedef logic [IdxW-1:0] idx_t;

    typedef enum logic [4:0] {
        OP_CLEAR     = 5'd0,
        OP_INS_HEAD  = 5'd1,
        OP_INS_TAIL  = 5'd2,
        OP_CUR_HEAD  = 5'd3,
        OP_CUR_TAIL  = 5'd4,
        OP_RD_HEAD   = 5'd5,
        OP_RD_TAIL   = 5'd6,
        OP_DEL_HEAD  = 5'd7,
        OP_DEL_TAIL  = 5'd8,
        OP_DEL_AFTER = 5'd9,
        OP_DEL_BEF   = 5'd10,
        OP_INS_AFTER = 5'd11,
        OP_INS_BEF   = 5'd12,
        OP_RD_CUR    = 5'd13,
        OP_WR_CUR    = 5'd14,
        OP_NEXT      = 5'd15,
        OP_PREV      = 5'd16,
        OP_QUERY     = 5'd17
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_OUT
    } state_t;
endpackage

>>> rtl/core/doubly_linked_list_with_cursor.sv
// Doubly linked list with cursor: top level, node pool memories, sequencer.
// Depends on dllc_pkg.
//
// One item is taken at a time and gives one result. After acceptance the
// sequencer reads the node picked by head, tail or cursor (S_RD1), then reads
// the neighbor named by that node's link (S_RD2), then evaluates the op and
// loads the result register (S_OUT). Up to three write-backs follow (target
// node, then neighbor or far node, then new node), one per node written, and
// no item is taken while they run. The next item is taken once the write-back
// is done and the result is taken or being taken. All link, value and
// free-stack arrays are synchronous-read memories; no clearing pass is needed
// after reset.
module doubly_linked_list_with_cursor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // op[4:0], value[36:5], zero pad [39:37]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // read_value[31:0], status[33:32],
                                  // cursor_active[34], list_empty[35], pad
);
    import dllc_pkg::*;

    typedef struct packed {
        logic [DataWidth-1:0] val;
        idx_t                 nxt;
        idx_t                 prv;
        logic                 hn;
        logic                 hp;
    } node_t;

    node_t   pool_mem [PoolSize];
    idx_t    free_mem [PoolSize];

    state_t state_reg, state_next;
    logic [4:0]           op_reg;
    logic [DataWidth-1:0] val_reg;
    logic [CntW-1:0] free_count_reg, bump_reg;
    idx_t head_reg, tail_reg, cur_reg;
    logic nonempty_reg, cval_reg;
    logic [39:0] out_reg;
    logic        out_valid_reg;

    // memory ports
    idx_t  ra_addr;
    node_t ra_q, rb_q;
    idx_t  fs_q;
    logic  we_a;
    idx_t  wa_addr;
    node_t wa_d;
    logic  fs_we;
    idx_t  fs_waddr, fs_wdata;

    // node A: target (head/tail/cursor); node B: neighbor of A.
    // Only one write port per cycle in use at a time: A, B, new node in sequence.
    always_ff @(posedge aclk) begin
        if (we_a) pool_mem[wa_addr] <= wa_d;
        ra_q <= pool_mem[ra_addr];
    end
    always_ff @(posedge aclk) begin
        if (fs_we) free_mem[fs_waddr] <= fs_wdata;
        fs_q <= free_mem[free_count_reg[IdxW-1:0] - 1'b1];
    end

    op_t  op;
    idx_t a_idx;
    node_t a_node;
    assign op = op_t'(op_reg);

    // write sequencing state, used by the read address below
    logic [1:0] sub_reg;
    idx_t  far_reg;
    logic  far_reg_v;
    logic  pend_reg;

    // pick node A from current state
    always_comb begin
        case (op)
            OP_INS_HEAD, OP_DEL_HEAD, OP_RD_HEAD: a_idx = head_reg;
            OP_INS_TAIL, OP_DEL_TAIL, OP_RD_TAIL: a_idx = tail_reg;
            default: a_idx = cur_reg;
        endcase
    end

    // neighbor read in S_RD2 from node A's links as they come out of memory;
    // write sub-step 1 reads the far node for the read-modify-write in sub-step 2
    always_comb begin
        ra_addr = a_idx;
        if (state_reg == S_RD2) begin
            case (op)
                OP_DEL_HEAD, OP_DEL_AFTER, OP_INS_AFTER: ra_addr = ra_q.nxt;
                default:                                  ra_addr = ra_q.prv;
            endcase
        end else if (pend_reg && sub_reg == 2'd1 && far_reg_v) begin
            ra_addr = far_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RD2) a_node <= ra_q;
    end
    assign rb_q = ra_q;

    idx_t  b_idx_reg, n_idx;
    node_t b_node;
    logic  alloc_ok, from_free;

    assign from_free = free_count_reg != '0;
    assign alloc_ok  = from_free || (bump_reg < CntW'(PoolSize));
    assign n_idx     = from_free ? fs_q : bump_reg[IdxW-1:0];
    assign b_node    = rb_q;

    always_ff @(posedge aclk) begin
        if (state_reg == S_RD2) b_idx_reg <= ra_addr;
    end

    // combinational op execution at S_OUT
    logic [1:0]  st;
    logic [DataWidth-1:0] rd;
    logic [CntW-1:0] fc_n, bp_n;
    idx_t h_n, t_n, c_n;
    logic ne_n, cv_n;
    logic [1:0] nw;
    node_t w0, w1, w2;
    idx_t  a0, a1, a2;
    logic  give;
    idx_t  gidx;
    logic  taken;

    always_comb begin
        st = ST_OK; rd = '0;
        fc_n = free_count_reg; bp_n = bump_reg;
        h_n = head_reg; t_n = tail_reg; c_n = cur_reg;
        ne_n = nonempty_reg; cv_n = cval_reg;
        nw = 2'd0; w0 = a_node; w1 = b_node; w2 = a_node;
        a0 = a_idx; a1 = b_idx_reg; a2 = n_idx;
        give = 1'b0; gidx = a_idx; taken = 1'b0;
        case (op)
            OP_CLEAR: begin
                fc_n = '0; bp_n = '0; ne_n = 1'b0; cv_n = 1'b0;
            end
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (!alloc_ok) st = ST_FULL;
                else begin
                    taken = 1'b1;
                    w2.val = val_reg;
                    if (op == OP_INS_HEAD) begin
                        w2.hp = 1'b0; w2.hn = nonempty_reg; w2.nxt = head_reg;
                        w2.prv = a_node.prv;
                        w0.prv = n_idx; w0.hp = 1'b1;
                        if (!nonempty_reg) t_n = n_idx;
                        h_n = n_idx;
                    end else begin
                        w2.hn = 1'b0; w2.hp = nonempty_reg; w2.prv = tail_reg;
                        w2.nxt = a_node.nxt;
                        w0.nxt = n_idx; w0.hn = 1'b1;
                        if (!nonempty_reg) h_n = n_idx;
                        t_n = n_idx;
                    end
                    // old end node, then new node; the neighbor is not touched
                    nw = 2'd2;
                    ne_n = 1'b1;
                end
            end
            OP_CUR_HEAD: begin c_n = head_reg; cv_n = nonempty_reg; end
            OP_CUR_TAIL: begin c_n = tail_reg; cv_n = nonempty_reg; end
            OP_RD_HEAD, OP_RD_TAIL: begin
                if (!nonempty_reg) st = ST_EMPTY;
                else rd = a_node.val;
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
                if (nonempty_reg) begin
                    if (cval_reg && cur_reg == a_idx) cv_n = 1'b0;
                    if (head_reg == tail_reg) ne_n = 1'b0;
                    else if (op == OP_DEL_HEAD) begin
                        h_n = b_idx_reg; w0 = b_node; w0.hp = 1'b0;
                        a0 = b_idx_reg; nw = 2'd1;
                    end else begin
                        t_n = b_idx_reg; w0 = b_node; w0.hn = 1'b0;
                        a0 = b_idx_reg; nw = 2'd1;
                    end
                    give = 1'b1;
                end
            end
            OP_DEL_AFTER: begin
                if (cval_reg && a_node.hn) begin
                    // B is the deleted node; its successor needs prev fixed
                    if (b_node.hn) begin
                        w0.nxt = b_node.nxt; nw = 2'd3;
                    end else begin
                        w0.hn = 1'b0; t_n = cur_reg; nw = 2'd1;
                    end
                    give = 1'b1; gidx = b_idx_reg;
                end
            end
            OP_DEL_BEF: begin
                if (cval_reg && a_node.hp) begin
                    if (b_node.hp) begin
                        w0.prv = b_node.prv; nw = 2'd3;
                    end else begin
                        w0.hp = 1'b0; h_n = cur_reg; nw = 2'd1;
                    end
                    give = 1'b1; gidx = b_idx_reg;
                end
            end
            OP_INS_AFTER, OP_INS_BEF: begin
                if (cval_reg) begin
                    if (!alloc_ok) st = ST_FULL;
                    else begin
                        taken = 1'b1;
                        w2.val = val_reg;
                        if (op == OP_INS_AFTER) begin
                            w2.prv = cur_reg; w2.hp = 1'b1;
                            w2.nxt = a_node.nxt; w2.hn = a_node.hn;
                            if (!a_node.hn) t_n = n_idx;
                            w0.nxt = n_idx; w0.hn = 1'b1;
                            w1.prv = n_idx;
                        end else begin
                            w2.nxt = cur_reg; w2.hn = 1'b1;
                            w2.prv = a_node.prv; w2.hp = a_node.hp;
                            if (!a_node.hp) h_n = n_idx;
                            w0.prv = n_idx; w0.hp = 1'b1;
                            w1.nxt = n_idx;
                        end
                        nw = (op == OP_INS_AFTER ? a_node.hn : a_node.hp) ? 2'd3 : 2'd2;
                    end
                end
            end
            OP_RD_CUR: begin
                if (!cval_reg) st = ST_EMPTY;
                else rd = a_node.val;
            end
            OP_WR_CUR: begin
                if (cval_reg) begin w0.val = val_reg; nw = 2'd1; end
            end
            OP_NEXT: begin
                if (cval_reg) begin
                    if (a_node.hn) c_n = a_node.nxt; else cv_n = 1'b0;
                end
            end
            OP_PREV: begin
                if (cval_reg) begin
                    if (a_node.hp) c_n = a_node.prv; else cv_n = 1'b0;
                end
            end
            default: ;
        endcase
        if (taken) begin
            if (from_free) fc_n = free_count_reg - 1'b1;
            else bp_n = bump_reg + 1'b1;
        end
        if (give && free_count_reg < CntW'(PoolSize)) fc_n = free_count_reg + 1'b1;
    end

    // deleting via DEL_AFTER/BEFORE with a far neighbor: fix its back link
    // by reading it and writing it back with that link set to A (far_fix).
    // Writes are performed in WRITE sub-steps: A, then B-side, then new node.
    node_t far_fix;
    idx_t  far_idx;
    logic  need_far;
    assign need_far = (op == OP_DEL_AFTER || op == OP_DEL_BEF) && nw == 2'd3;
    assign far_idx  = (op == OP_DEL_AFTER) ? b_node.nxt : b_node.prv;

    // held results of S_OUT evaluation
    node_t w0_reg, w1_reg, w2_reg;
    idx_t  a0_reg, a1_reg, a2_reg;
    logic [1:0] nw_reg;
    logic  dir_after_reg;

    // far node read/modify/write for delete beside cursor
    always_comb begin
        far_fix = ra_q;
        if (dir_after_reg) far_fix.prv = a0_reg;
        else               far_fix.nxt = a0_reg;
    end

    always_comb begin
        we_a = 1'b0; wa_addr = a0_reg; wa_d = w0_reg;
        case (sub_reg)
            2'd1: begin we_a = 1'b1; end
            2'd2: begin
                if (far_reg_v) begin wa_addr = far_reg; wa_d = far_fix; end
                else begin wa_addr = a1_reg; wa_d = w1_reg; end
                we_a = 1'b1;
            end
            2'd3: begin wa_addr = a2_reg; wa_d = w2_reg; we_a = 1'b1; end
            default: ;
        endcase
    end
    assign fs_we    = state_reg == S_OUT && give && free_count_reg < CntW'(PoolSize);
    assign fs_waddr = free_count_reg[IdxW-1:0];
    assign fs_wdata = gidx;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = state_reg == S_IDLE && !pend_reg && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            free_count_reg <= '0; bump_reg <= '0;
            head_reg <= '0; tail_reg <= '0; cur_reg <= '0;
            nonempty_reg <= 1'b0; cval_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sub_reg <= 2'd0; pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (s_tvalid && s_tready) begin
                op_reg  <= s_tdata[4:0];
                val_reg <= s_tdata[36:5];
            end
            if (state_reg == S_OUT) begin
                free_count_reg <= fc_n; bump_reg <= bp_n;
                head_reg <= h_n; tail_reg <= t_n; cur_reg <= c_n;
                nonempty_reg <= ne_n; cval_reg <= cv_n;
                out_reg <= {4'b0, ~ne_n, cv_n, st, rd};
                out_valid_reg <= 1'b1;
                w0_reg <= w0; w1_reg <= w1; w2_reg <= w2;
                a0_reg <= a0; a1_reg <= a1; a2_reg <= a2;
                far_reg <= far_idx; far_reg_v <= need_far;
                dir_after_reg <= op == OP_DEL_AFTER;
                nw_reg <= nw;
                if (nw != 2'd0) begin sub_reg <= 2'd1; pend_reg <= 1'b1; end
            end else if (pend_reg) begin
                // writes of A, then B or far node, then new node
                if (sub_reg == 2'd1 && nw_reg == 2'd1) begin
                    sub_reg <= 2'd0; pend_reg <= 1'b0;
                end else if (sub_reg == 2'd1 && nw_reg == 2'd2) begin
                    sub_reg <= 2'd3;
                end else if (sub_reg == 2'd1) begin
                    sub_reg <= 2'd2;
                end else if (sub_reg == 2'd2 && far_reg_v) begin
                    sub_reg <= 2'd0; pend_reg <= 1'b0;
                end else if (sub_reg == 2'd2) begin
                    sub_reg <= 2'd3;
                end else begin
                    sub_reg <= 2'd0; pend_reg <= 1'b0;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT |=> m_tvalid) else $error("no result after op");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !s_tready) else $error("item accepted during writeback");
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= CntW'(PoolSize) && bump_reg <= CntW'(PoolSize))
        else $error("pool counters out of range");
    a_cursor_needs_list: assert property (@(posedge aclk) disable iff (!aresetn)
        cval_reg |-> nonempty_reg) else $error("cursor active on empty list");
`endif
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the doubly linked list with cursor: directed and random
// list ops are checked against a behavioral list model held here. Depends on dllc_pkg.
module tb_top;
    import dllc_pkg::*;

    localparam int NumRandom = 1430;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    doubly_linked_list_with_cursor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic        empty;
        logic        cur_act;
        logic [1:0]  status;
        logic [31:0] rd;
    } resp_t;

    // list model
    logic [31:0] vals [PoolSize];
    idx_t        nxt [PoolSize];
    idx_t        prv [PoolSize];
    logic        hn [PoolSize];
    logic        hp [PoolSize];
    idx_t        fstk [PoolSize];
    int          fcnt, bump;
    idx_t        head, tail, cur;
    logic        filled, cvalid;

    logic [39:0] pending_items[$];
    resp_t       expected_resp[$];
    bit          failed;
    bit          stim_done;
    int          tx_wait, rx_wait;

    function automatic bit alloc_node(output idx_t n);
        if (fcnt > 0) begin
            fcnt--;
            n = fstk[fcnt];
            return 1;
        end
        if (bump < PoolSize) begin
            n = idx_t'(bump);
            bump++;
            return 1;
        end
        return 0;
    endfunction

    function automatic void free_node(idx_t n);
        if (fcnt < PoolSize) begin
            fstk[fcnt] = n;
            fcnt++;
        end
    endfunction

    function automatic resp_t apply_list_op(logic [4:0] op, logic [31:0] v);
        resp_t r;
        idx_t n, t, c;
        r = '0;
        c = cur;
        case (op)
            OP_CLEAR: begin
                fcnt = 0; bump = 0; filled = 0; cvalid = 0;
            end
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (!alloc_node(n)) r.status = ST_FULL;
                else begin
                    vals[n] = v;
                    if (op == OP_INS_HEAD) begin
                        hp[n] = 0; hn[n] = filled; nxt[n] = head;
                        if (filled) begin prv[head] = n; hp[head] = 1; end
                        else tail = n;
                        head = n;
                    end else begin
                        hn[n] = 0; hp[n] = filled; prv[n] = tail;
                        if (filled) begin nxt[tail] = n; hn[tail] = 1; end
                        else head = n;
                        tail = n;
                    end
                    filled = 1;
                end
            end
            OP_CUR_HEAD, OP_CUR_TAIL: begin
                cur = (op == OP_CUR_HEAD) ? head : tail;
                cvalid = filled;
            end
            OP_RD_HEAD, OP_RD_TAIL: begin
                if (!filled) r.status = ST_EMPTY;
                else r.rd = vals[op == OP_RD_HEAD ? head : tail];
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
                if (filled) begin
                    t = (op == OP_DEL_HEAD) ? head : tail;
                    if (cvalid && c == t) cvalid = 0;
                    if (head == tail) filled = 0;
                    else if (op == OP_DEL_HEAD) begin
                        head = nxt[t]; hp[head] = 0;
                    end else begin
                        tail = prv[t]; hn[tail] = 0;
                    end
                    free_node(t);
                end
            end
            OP_DEL_AFTER: begin
                if (cvalid && hn[c]) begin
                    t = nxt[c];
                    if (hn[t]) begin nxt[c] = nxt[t]; prv[nxt[t]] = c; end
                    else begin hn[c] = 0; tail = c; end
                    free_node(t);
                end
            end
            OP_DEL_BEF: begin
                if (cvalid && hp[c]) begin
                    t = prv[c];
                    if (hp[t]) begin prv[c] = prv[t]; nxt[prv[t]] = c; end
                    else begin hp[c] = 0; head = c; end
                    free_node(t);
                end
            end
            OP_INS_AFTER: begin
                if (cvalid) begin
                    if (!alloc_node(n)) r.status = ST_FULL;
                    else begin
                        vals[n] = v; prv[n] = c; hp[n] = 1;
                        nxt[n] = nxt[c]; hn[n] = hn[c];
                        if (hn[c]) prv[nxt[c]] = n;
                        else tail = n;
                        nxt[c] = n; hn[c] = 1;
                    end
                end
            end
            OP_INS_BEF: begin
                if (cvalid) begin
                    if (!alloc_node(n)) r.status = ST_FULL;
                    else begin
                        vals[n] = v; nxt[n] = c; hn[n] = 1;
                        prv[n] = prv[c]; hp[n] = hp[c];
                        if (hp[c]) nxt[prv[c]] = n;
                        else head = n;
                        prv[c] = n; hp[c] = 1;
                    end
                end
            end
            OP_RD_CUR: begin
                if (!cvalid) r.status = ST_EMPTY;
                else r.rd = vals[c];
            end
            OP_WR_CUR: if (cvalid) vals[c] = v;
            OP_NEXT: begin
                if (cvalid) begin
                    if (hn[c]) cur = nxt[c];
                    else cvalid = 0;
                end
            end
            OP_PREV: begin
                if (cvalid) begin
                    if (hp[c]) cur = prv[c];
                    else cvalid = 0;
                end
            end
            default: ;
        endcase
        r.cur_act = cvalid;
        r.empty = !filled;
        return r;
    endfunction

    task automatic queue_op(logic [4:0] op, logic [31:0] v);
        pending_items.push_back({3'b000, v, op});
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // driver: model updated as each item is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait <= $urandom_range(0, 14);
        end else if (s_tvalid && !s_tready) begin
        end else begin
            if (s_tvalid)
                expected_resp.push_back(apply_list_op(s_tdata[4:0], s_tdata[36:5]));
            if (tx_wait > 0) begin
                s_tvalid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (pending_items.size() > 0) begin
                s_tdata <= pending_items.pop_front();
                s_tvalid <= 1'b1;
                tx_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        resp_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[35:0];
                if (expected_resp.size() == 0) begin
                    $error("result with none expected: %h", m_tdata);
                    failed = 1;
                end else begin
                    want = expected_resp.pop_front();
                    if (got.rd !== want.rd) begin
                        $error("read_value exp %h got %h", want.rd, got.rd); failed = 1;
                    end
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status); failed = 1;
                    end
                    if (got.cur_act !== want.cur_act) begin
                        $error("cursor_active exp %b got %b", want.cur_act, got.cur_act);
                        failed = 1;
                    end
                    if (got.empty !== want.empty) begin
                        $error("list_empty exp %b got %b", want.empty, got.empty); failed = 1;
                    end
                end
                rx_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
    end

    initial begin
        int op, sz;
        failed = 0;
        stim_done = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        aresetn = 1'b0;
        fcnt = 0; bump = 0; head = '0; tail = '0; cur = '0;
        filled = 0; cvalid = 0;
        // empty-list, inactive-cursor and unused op code cases
        queue_op(OP_RD_HEAD, 0); queue_op(OP_RD_TAIL, 0); queue_op(OP_DEL_HEAD, 0);
        queue_op(OP_DEL_TAIL, 0); queue_op(OP_CUR_HEAD, 0); queue_op(OP_RD_CUR, 0);
        queue_op(OP_INS_AFTER, 1); queue_op(OP_NEXT, 0); queue_op(OP_PREV, 0);
        queue_op(5'd31, 32'hffff_ffff); queue_op(OP_QUERY, 0);
        // single element deleted, then a short list walked and edited
        queue_op(OP_INS_HEAD, 32'h7fff_ffff); queue_op(OP_CUR_HEAD, 0);
        queue_op(OP_DEL_TAIL, 0);
        queue_op(OP_INS_TAIL, 32'h8000_0000); queue_op(OP_INS_HEAD, 32'hffff_ffff);
        queue_op(OP_CUR_TAIL, 0); queue_op(OP_INS_BEF, 5); queue_op(OP_DEL_BEF, 0);
        queue_op(OP_WR_CUR, 32'h1234_5678); queue_op(OP_RD_CUR, 0); queue_op(OP_PREV, 0);
        queue_op(OP_DEL_AFTER, 0); queue_op(OP_NEXT, 0); queue_op(OP_CLEAR, 0);
        // random: bursts that fill the pool, then mixed edits and walks
        for (int i = 0; i < NumRandom; i++) begin
            if (i % 300 == 150) begin
                for (int k = 0; k < 70; k++)
                    queue_op(($urandom_range(0, 1) != 0) ? OP_INS_HEAD : OP_INS_TAIL,
                             rand_value());
                queue_op(OP_CUR_HEAD, 0);
                queue_op(OP_INS_AFTER, rand_value());
                queue_op(OP_INS_BEF, rand_value());
                i += 72;
                continue;
            end
            sz = $urandom_range(0, 99);
            if (sz < 30) op = $urandom_range(1, 2);
            else if (sz < 45) op = $urandom_range(11, 12);
            else if (sz < 48) op = OP_CLEAR;
            else if (sz < 50) op = $urandom_range(18, 31);
            else op = $urandom_range(3, 17);
            queue_op(5'(op), rand_value());
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        while (expected_resp.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (!failed && expected_resp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
